// ----- hdl/sra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_pkg: shared types and constants for the signed radix to ASCII converter
// Holds the radix limits, character codes, divider step size, the
// controller state type, the command/status bundles and the digit_char function.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 8;

  // quotient bits retired per divider cycle
  localparam int STEP_BITS = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_LIMIT = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_SEND_SIGN,
    ST_READ,
    ST_SEND
  } sra_state_t;

  typedef struct packed {
    logic load;       // capture value, start first digit
    logic step;       // run one divider step
    logic out_sign;   // load '-' into the output register
    logic out_digit;  // load top stacked digit into the output register
    logic ptr_dec;    // pop the digit stack
  } sra_cmd_t;

  typedef struct packed {
    logic step_last;  // current divider cycle finishes a digit
    logic q_zero;     // quotient after this cycle is zero
    logic neg;        // value being converted is negative
    logic ptr_zero;   // stack pointer at the least significant digit
  } sra_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_LIMIT) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d) - CHAR_W'(DIGIT_LIMIT);
    end
    return c;
  endfunction

endpackage

// ----- hdl/sra_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_ifs: channel interfaces of the signed radix to ASCII converter
// Input value channel, output character channel and radix write channel.
// ----------------------------------------------------------------------------
interface sra_in_if #(
  parameter int VALUE_BITS = sra_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sra_out_if;
  logic                        valid;
  logic                        ready;
  logic [sra_pkg::CHAR_W-1:0]  character;
  logic                        last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface sra_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [sra_pkg::RADIX_W-1:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

// ----- hdl/signed_radix_to_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_radix_to_ascii: signed integer to ASCII text in base 2..36
// Converts one signed value into characters, most significant first, with
// a leading '-' for negative values and a last flag on the final character.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                 handshake
//   in_if     in    value [VALUE_BITS]      valid/ready
//   out_if    out   character [8], last     valid/ready
//   cfg_if    in    radix [6]               valid/ready (ready always high)
//
// One value at a time. Each digit is one full pass of the radix divider over
// the quotient; the divider retires four quotient bits per cycle.
// Reset is synchronous on rst_n and restores the radix to 10; no clearing
// pass. A character stalled by out_if.ready low holds in the output register.
// ----------------------------------------------------------------------------
module signed_radix_to_ascii #(
  parameter int VALUE_BITS = sra_pkg::VALUE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  sra_in_if.sink   in_if,
  sra_out_if.source out_if,
  sra_cfg_if.sink  cfg_if
);

  sra_pkg::sra_cmd_t cmd;
  sra_pkg::sra_sts_t sts;

  assign cfg_if.ready = 1'b1;

  sra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sra_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_if.value),
    .cfg_we        (cfg_if.valid),
    .cfg_radix     (cfg_if.radix),
    .cmd           (cmd),
    .sts           (sts),
    .out_character (out_if.character),
    .out_last      (out_if.last)
  );

endmodule

// ----- hdl/sra_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_ctrl: sequencer of the signed radix to ASCII converter
// Steps the datapath through division, sign output and digit output,
// and runs the input and output handshakes.
// ----------------------------------------------------------------------------
module sra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sra_pkg::sra_sts_t sts,
  output sra_pkg::sra_cmd_t cmd
);

  sra_pkg::sra_state_t state_r;
  sra_pkg::sra_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sra_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      sra_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sra_pkg::ST_DIV;
        end
      end
      sra_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.step_last && sts.q_zero) begin
          state_nxt = sts.neg ? sra_pkg::ST_SIGN : sra_pkg::ST_READ;
        end
      end
      sra_pkg::ST_SIGN: begin
        cmd.out_sign = 1'b1;
        state_nxt    = sra_pkg::ST_SEND_SIGN;
      end
      sra_pkg::ST_SEND_SIGN: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = sra_pkg::ST_READ;
        end
      end
      sra_pkg::ST_READ: begin
        cmd.out_digit = 1'b1;
        state_nxt     = sra_pkg::ST_SEND;
      end
      sra_pkg::ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.ptr_zero) begin
            state_nxt = sra_pkg::ST_IDLE;
          end else begin
            cmd.ptr_dec = 1'b1;
            state_nxt   = sra_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_nxt = sra_pkg::ST_IDLE;
      end
    endcase
  end

  // a new value is never taken while a character is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while output busy");

  // the block only returns to idle after handing off a final character
  a_idle_after_send: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && state_r == sra_pkg::ST_IDLE && $past(state_r) != sra_pkg::ST_IDLE)
      |-> $past(out_valid && out_ready && sts.ptr_zero))
    else $error("returned to idle without final transaction");

  // division ends only on a digit boundary
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sra_pkg::ST_DIV && state_nxt != sra_pkg::ST_DIV) |-> sts.step_last)
    else $error("division left mid-digit");

endmodule

// ----- hdl/sra_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_dpath: datapath of the signed radix to ASCII converter
// Radix register, magnitude/quotient register, multi-bit restoring divider,
// digit stack memory and the output character register.
// ----------------------------------------------------------------------------
module sra_dpath #(
  parameter int VALUE_BITS = sra_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  input  logic                          cfg_we,
  input  logic [sra_pkg::RADIX_W-1:0]   cfg_radix,
  input  sra_pkg::sra_cmd_t             cmd,
  output sra_pkg::sra_sts_t             sts,
  output logic [sra_pkg::CHAR_W-1:0]    out_character,
  output logic                          out_last
);

  localparam int SB     = sra_pkg::STEP_BITS;
  localparam int QW     = ((VALUE_BITS + SB - 1) / SB) * SB;
  localparam int NSTEPS = QW / SB;
  localparam int SW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
  localparam int PW     = $clog2(VALUE_BITS);
  localparam int RW     = sra_pkg::RADIX_W;

  logic [RW-1:0]          radix_r;
  logic [QW-1:0]          q_r;
  logic [RW-1:0]          rem_r;
  logic [SW-1:0]          step_cnt_r;
  logic [PW-1:0]          wr_ptr_r;
  logic                   neg_r;
  logic [sra_pkg::CHAR_W-1:0] char_r;
  logic                   last_r;
  logic [RW-1:0]          stack_mem [VALUE_BITS];

  logic [VALUE_BITS-1:0]  raw;
  logic [VALUE_BITS-1:0]  mag;
  logic [RW:0]            r_work;
  logic [QW-1:0]          q_work;
  logic                   step_last;

  // radix write, clamped to the legal range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= sra_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      if (cfg_radix < sra_pkg::RADIX_MIN) begin
        radix_r <= sra_pkg::RADIX_MIN;
      end else if (cfg_radix > sra_pkg::RADIX_MAX) begin
        radix_r <= sra_pkg::RADIX_MAX;
      end else begin
        radix_r <= cfg_radix;
      end
    end
  end

  assign raw = VALUE_BITS'(unsigned'(in_value));
  assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  // SB bits of restoring division by the radix
  always_comb begin
    r_work = {1'b0, rem_r};
    q_work = q_r;
    for (int i = 0; i < SB; i++) begin
      r_work = {r_work[RW-1:0], q_work[QW-1]};
      q_work = {q_work[QW-2:0], 1'b0};
      if (r_work >= {1'b0, radix_r}) begin
        r_work    = r_work - {1'b0, radix_r};
        q_work[0] = 1'b1;
      end
    end
  end

  assign step_last = (step_cnt_r == SW'(NSTEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r      <= '0;
      step_cnt_r <= '0;
      wr_ptr_r   <= '0;
    end else if (cmd.load) begin
      rem_r      <= '0;
      step_cnt_r <= '0;
      wr_ptr_r   <= '0;
    end else if (cmd.step) begin
      if (step_last) begin
        rem_r      <= '0;
        step_cnt_r <= '0;
        if (q_work != '0) begin
          wr_ptr_r <= wr_ptr_r + 1'b1;
        end
      end else begin
        rem_r      <= r_work[RW-1:0];
        step_cnt_r <= step_cnt_r + 1'b1;
      end
    end else if (cmd.ptr_dec) begin
      wr_ptr_r <= wr_ptr_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r   <= QW'(mag);
      neg_r <= raw[VALUE_BITS-1];
    end else if (cmd.step) begin
      q_r <= q_work;
    end
  end

  // push each finished digit
  always_ff @(posedge clk) begin
    if (cmd.step && step_last) begin
      stack_mem[wr_ptr_r] <= r_work[RW-1:0];
    end
  end

  // load the minus sign or pop a digit into the output register, most significant digit first
  always_ff @(posedge clk) begin
    if (cmd.out_sign) begin
      char_r <= sra_pkg::CHAR_MINUS;
      last_r <= 1'b0;
    end else if (cmd.out_digit) begin
      char_r <= sra_pkg::digit_char(stack_mem[wr_ptr_r]);
      last_r <= (wr_ptr_r == '0);
    end
  end

  assign sts.step_last = step_last;
  assign sts.q_zero    = (q_work == '0);
  assign sts.neg       = neg_r;
  assign sts.ptr_zero  = (wr_ptr_r == '0);

  assign out_character = char_r;
  assign out_last      = last_r;

  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    (radix_r >= sra_pkg::RADIX_MIN) && (radix_r <= sra_pkg::RADIX_MAX))
    else $error("radix register out of range");

  // a value never produces more digits than the stack holds
  a_stack_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && step_last && q_work != '0) |-> (wr_ptr_r < PW'(VALUE_BITS - 1)))
    else $error("digit stack overflow");

endmodule
